[src/pipe_chain_bottleneck_finder_top_macros.svh]
// Assertion macros for the pipe chain bottleneck finder.
// Used by pcbf_datapath.sv; expects clk_i and rst_ni in scope.
`ifndef PIPE_CHAIN_BOTTLENECK_FINDER_TOP_MACROS_SVH
`define PIPE_CHAIN_BOTTLENECK_FINDER_TOP_MACROS_SVH

// Plain property, checked on every rising edge outside reset.
`define PCBF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define PCBF_ASSERT_IMP(lbl, ante, cons, msg) \
  `PCBF_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define PCBF_ASSERT_NXT(lbl, ante, cons, msg) \
  `PCBF_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

[src/pcbf_pkg.sv]
// Package for the pipe chain bottleneck finder: sizes, codes and the
// controller/datapath command and status structs. No dependencies.
`default_nettype none

package pcbf_pkg;

  localparam int unsigned MAX_HOUSES = 64;
  localparam int unsigned HOUSE_W    = 7;
  localparam int unsigned IDX_W      = $clog2(MAX_HOUSES);
  localparam int unsigned STEP_W     = $clog2(MAX_HOUSES + 1);
  localparam int unsigned DIAM_W     = 16;
  localparam int unsigned CHAIN_CAP  = 32;
  localparam int unsigned TOTAL_W    = 6;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned SUCC_W     = HOUSE_W + DIAM_W;

  localparam logic [HOUSE_W-1:0] HOUSE_MAX  = HOUSE_W'(MAX_HOUSES);
  localparam logic [HOUSE_W-1:0] HC_RESET   = HOUSE_W'(64);
  localparam logic [STEP_W-1:0]  STEP_MAX   = STEP_W'(MAX_HOUSES);
  localparam logic [TOTAL_W-1:0] CHAIN_FULL = TOTAL_W'(CHAIN_CAP);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_SOLVE = 2'd1,
    OP_CLEAR = 2'd2
  } pcbf_op_e;

  typedef struct packed {
    logic load_pipe;
    logic clear_tbl;
    logic solve_init;
    logic cnt_tank;
    logic scan_init;
    logic h_inc;
    logic walk_init;
    logic rd_walk;
    logic walk_step;
    logic emit;
  } pcbf_cmd_t;

  typedef struct packed {
    logic h_over;
    logic n_full;
    logic n_zero;
    logic tank;
    logic nx_zero;
    logic steps_max;
    logic last;
    logic out_free;
  } pcbf_sts_t;

  typedef struct packed {
    logic [HOUSE_W-1:0] tank_house;
    logic [HOUSE_W-1:0] tap_house;
    logic [DIAM_W-1:0]  bottleneck;
    logic [TOTAL_W-1:0] chain_total;
    logic               found;
    logic               last;
  } pcbf_rec_t;

endpackage

`default_nettype wire

[src/pcbf_if.sv]
// Channel interfaces: configuration write, input item and result record.
// Field widths come from pcbf_pkg.
`default_nettype none

interface pcbf_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [pcbf_pkg::HOUSE_W-1:0] house_count;
  modport source (output valid, output house_count, input ready);
  modport sink   (input valid, input house_count, output ready);
endinterface

interface pcbf_in_if;
  logic                         valid;
  logic                         ready;
  logic [pcbf_pkg::OP_W-1:0]    operation;
  logic [pcbf_pkg::HOUSE_W-1:0] from_house;
  logic [pcbf_pkg::HOUSE_W-1:0] to_house;
  logic [pcbf_pkg::DIAM_W-1:0]  diameter;
  modport source (output valid, output operation, output from_house, output to_house,
                  output diameter, input ready);
  modport sink   (input valid, input operation, input from_house, input to_house,
                  input diameter, output ready);
endinterface

interface pcbf_out_if;
  logic                         valid;
  logic                         ready;
  logic [pcbf_pkg::HOUSE_W-1:0] tank_house;
  logic [pcbf_pkg::HOUSE_W-1:0] tap_house;
  logic [pcbf_pkg::DIAM_W-1:0]  bottleneck;
  logic [pcbf_pkg::TOTAL_W-1:0] chain_total;
  logic                         found;
  logic                         last;
  modport source (output valid, output tank_house, output tap_house, output bottleneck,
                  output chain_total, output found, output last, input ready);
  modport sink   (input valid, input tank_house, input tap_house, input bottleneck,
                  input chain_total, input found, input last, output ready);
endinterface

`default_nettype wire

[src/pcbf_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pcbf_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[src/pcbf_datapath.sv]
// Datapath: pipe tables (two RAMs plus per-entry valid bits), scan and walk
// counters, running minimum and the result register. Uses pcbf_pkg, pcbf_ram.
`default_nettype none
`include "pipe_chain_bottleneck_finder_top_macros.svh"

module pcbf_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pcbf_pkg::HOUSE_W-1:0]        cfg_data_i,
  input  logic [pcbf_pkg::HOUSE_W-1:0]        from_i,
  input  logic [pcbf_pkg::HOUSE_W-1:0]        to_i,
  input  logic [pcbf_pkg::DIAM_W-1:0]         dia_i,
  input  pcbf_pkg::pcbf_cmd_t                 cmd_i,
  output pcbf_pkg::pcbf_sts_t                 sts_o,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output pcbf_pkg::pcbf_rec_t                 out_rec_o
);

  import pcbf_pkg::*;

  logic [HOUSE_W-1:0]    house_count_q;
  logic [HOUSE_W-1:0]    h_q;
  logic [HOUSE_W-1:0]    w_q;
  logic [TOTAL_W-1:0]    n_q;
  logic [TOTAL_W-1:0]    k_q;
  logic [STEP_W-1:0]     steps_q;
  logic [DIAM_W-1:0]     running_min_q;
  logic [MAX_HOUSES-1:0] vs_q;
  logic [MAX_HOUSES-1:0] vp_q;
  logic                  rvs_q;
  logic                  rvp_q;
  logic                  out_valid_q;
  pcbf_rec_t             out_rec_q;

  logic [HOUSE_W-1:0] from_idx;
  logic [HOUSE_W-1:0] to_idx;
  logic [HOUSE_W-1:0] h_idx;
  logic [HOUSE_W-1:0] w_idx;
  logic [HOUSE_W-1:0] limit;
  logic               load_ok;
  logic               tbl_we;
  logic [IDX_W-1:0]   s_raddr;
  logic [IDX_W-1:0]   p_raddr;
  logic [SUCC_W-1:0]  s_rdata;
  logic [HOUSE_W-1:0] p_rdata;
  logic [HOUSE_W-1:0] nx;
  logic [DIAM_W-1:0]  dia_rd;
  logic               rec_last;
  pcbf_rec_t          rec_d;

  assign from_idx = from_i - HOUSE_W'(1);
  assign to_idx   = to_i - HOUSE_W'(1);
  assign h_idx    = h_q - HOUSE_W'(1);
  assign w_idx    = w_q - HOUSE_W'(1);
  assign limit    = (house_count_q > HOUSE_MAX) ? HOUSE_MAX : house_count_q;

  assign load_ok = (from_i != '0) && (from_i <= HOUSE_MAX) &&
                   (to_i != '0) && (to_i <= HOUSE_MAX);
  assign tbl_we  = cmd_i.load_pipe && load_ok;

  assign s_raddr = cmd_i.rd_walk ? w_idx[IDX_W-1:0] : h_idx[IDX_W-1:0];
  assign p_raddr = h_idx[IDX_W-1:0];

  // successor and diameter share an entry: {to, diameter}
  pcbf_ram #(.Width(SUCC_W), .Depth(MAX_HOUSES)) u_succ_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (from_idx[IDX_W-1:0]),
    .wdata_i ({to_i, dia_i}),
    .raddr_i (s_raddr),
    .rdata_o (s_rdata)
  );

  pcbf_ram #(.Width(HOUSE_W), .Depth(MAX_HOUSES)) u_pred_ram (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (to_idx[IDX_W-1:0]),
    .wdata_i (from_i),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // entries never written since reset or clear read as zero
  assign nx     = rvs_q ? s_rdata[SUCC_W-1 -: HOUSE_W] : '0;
  assign dia_rd = rvs_q ? s_rdata[DIAM_W-1:0] : '0;

  assign rec_last = (n_q == '0) || ((k_q + TOTAL_W'(1)) == n_q);

  always_comb begin
    sts_o.h_over    = h_q > limit;
    sts_o.n_full    = n_q == CHAIN_FULL;
    sts_o.n_zero    = n_q == '0;
    sts_o.tank      = (nx != '0) && !(rvp_q && (p_rdata != '0));
    sts_o.nx_zero   = nx == '0;
    sts_o.steps_max = steps_q == STEP_MAX;
    sts_o.last      = rec_last;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  always_comb begin
    if (n_q == '0) begin
      rec_d       = '0;
      rec_d.last  = 1'b1;
    end else begin
      rec_d.tank_house  = h_q;
      rec_d.tap_house   = w_q;
      rec_d.bottleneck  = running_min_q;
      rec_d.chain_total = n_q;
      rec_d.found       = 1'b1;
      rec_d.last        = rec_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      house_count_q <= HC_RESET;
      h_q           <= '0;
      w_q           <= '0;
      n_q           <= '0;
      k_q           <= '0;
      steps_q       <= '0;
      running_min_q <= '1;
      vs_q          <= '0;
      vp_q          <= '0;
      rvs_q         <= 1'b0;
      rvp_q         <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        house_count_q <= cfg_data_i;
      end

      if (cmd_i.clear_tbl) begin
        vs_q <= '0;
        vp_q <= '0;
      end else if (tbl_we) begin
        vs_q[from_idx[IDX_W-1:0]] <= 1'b1;
        vp_q[to_idx[IDX_W-1:0]]   <= 1'b1;
      end
      rvs_q <= vs_q[s_raddr];
      rvp_q <= vp_q[p_raddr];

      if (cmd_i.solve_init || cmd_i.scan_init) begin
        h_q <= HOUSE_W'(1);
      end else if (cmd_i.h_inc) begin
        h_q <= h_q + HOUSE_W'(1);
      end

      if (cmd_i.solve_init) begin
        n_q <= '0;
      end else if (cmd_i.cnt_tank && sts_o.tank) begin
        n_q <= n_q + TOTAL_W'(1);
      end

      if (cmd_i.scan_init) begin
        k_q <= '0;
      end else if (cmd_i.emit) begin
        k_q <= k_q + TOTAL_W'(1);
      end

      if (cmd_i.walk_init) begin
        w_q           <= h_q;
        steps_q       <= '0;
        running_min_q <= '1;
      end else if (cmd_i.walk_step) begin
        w_q     <= nx;
        steps_q <= steps_q + STEP_W'(1);
        if (dia_rd < running_min_q) begin
          running_min_q <= dia_rd;
        end
      end

      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_rec_q <= rec_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rec_o   = out_rec_q;

  `PCBF_ASSERT(a_steps_bound, steps_q <= STEP_MAX, "walk step count beyond table size")
  `PCBF_ASSERT(a_count_bound, n_q <= CHAIN_FULL, "chain count beyond cap")
  `PCBF_ASSERT_IMP(a_found_rec, out_valid_q && out_rec_q.found, (out_rec_q.tank_house != '0) && (out_rec_q.tap_house != '0) && (out_rec_q.chain_total != '0), "found record with empty fields")
  `PCBF_ASSERT_NXT(a_walk_keeps_tank, cmd_i.walk_step, $stable(h_q), "tank moved during walk")

endmodule

`default_nettype wire

[src/pcbf_ctrl.sv]
// Controller state machine: sequences load, clear, the counting pass,
// the scan pass and each chain walk. Uses pcbf_pkg.
`default_nettype none

module pcbf_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [pcbf_pkg::OP_W-1:0]  operation_i,
  output logic                       in_ready_o,
  input  pcbf_pkg::pcbf_sts_t        sts_i,
  output pcbf_pkg::pcbf_cmd_t        cmd_o
);

  import pcbf_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CNT_RD   = 3'd1;
  localparam logic [2:0] S_CNT_CHK  = 3'd2;
  localparam logic [2:0] S_SCAN_RD  = 3'd3;
  localparam logic [2:0] S_SCAN_CHK = 3'd4;
  localparam logic [2:0] S_WALK_RD  = 3'd5;
  localparam logic [2:0] S_WALK_CHK = 3'd6;
  localparam logic [2:0] S_EMIT     = 3'd7;

  logic [2:0] state_q;
  logic [2:0] state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (operation_i)
            OP_LOAD:  cmd_o.load_pipe = 1'b1;
            OP_CLEAR: cmd_o.clear_tbl = 1'b1;
            OP_SOLVE: begin
              cmd_o.solve_init = 1'b1;
              state_d          = S_CNT_RD;
            end
            default: ;
          endcase
        end
      end
      // first pass only counts tanks, so every record can carry the total
      S_CNT_RD: begin
        if (sts_i.h_over || sts_i.n_full) begin
          if (sts_i.n_zero) begin
            state_d = S_EMIT;
          end else begin
            cmd_o.scan_init = 1'b1;
            state_d         = S_SCAN_RD;
          end
        end else begin
          state_d = S_CNT_CHK;
        end
      end
      S_CNT_CHK: begin
        cmd_o.cnt_tank = 1'b1;
        cmd_o.h_inc    = 1'b1;
        state_d        = S_CNT_RD;
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (sts_i.tank) begin
          cmd_o.walk_init = 1'b1;
          state_d         = S_WALK_RD;
        end else begin
          cmd_o.h_inc = 1'b1;
          state_d     = S_SCAN_RD;
        end
      end
      S_WALK_RD: begin
        if (sts_i.steps_max) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.rd_walk = 1'b1;
          state_d       = S_WALK_CHK;
        end
      end
      S_WALK_CHK: begin
        if (sts_i.nx_zero) begin
          state_d = S_EMIT;
        end else begin
          cmd_o.walk_step = 1'b1;
          state_d         = S_WALK_RD;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.h_inc = 1'b1;
            state_d     = S_SCAN_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

[src/pipe_chain_bottleneck_finder_top.sv]
// Pipe chain bottleneck finder. Load, clear and unused operations are taken
// in the idle state. A solve first counts tanks over houses 1..min(house_count,
// 64), stopping early at 32 tanks, then rescans up to the last counted tank;
// for each tank it walks the chain link by link until the chain ends or the
// walk runs out of steps, and emits one record per tank (a single not-found
// record if there is none), waiting while the result side stalls. Reads go
// through the single read port of each table RAM. Tables empty at once on
// reset and on clear (per-entry valid bits), with no clearing pass. The last
// record may wait in the output register while the next item is taken.
`default_nettype none

module pipe_chain_bottleneck_finder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  pcbf_cfg_if.sink    cfg_i,
  pcbf_in_if.sink     in_i,
  pcbf_out_if.source  out_o
);

  import pcbf_pkg::*;

  pcbf_cmd_t cmd;
  pcbf_sts_t sts;
  pcbf_rec_t rec;
  logic      in_ready;
  logic      out_valid;

  assign cfg_i.ready = 1'b1;

  pcbf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .operation_i (in_i.operation),
    .in_ready_o  (in_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  pcbf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_i.valid),
    .cfg_data_i  (cfg_i.house_count),
    .from_i      (in_i.from_house),
    .to_i        (in_i.to_house),
    .dia_i       (in_i.diameter),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_valid),
    .out_rec_o   (rec)
  );

  assign in_i.ready        = in_ready;
  assign out_o.valid       = out_valid;
  assign out_o.tank_house  = rec.tank_house;
  assign out_o.tap_house   = rec.tap_house;
  assign out_o.bottleneck  = rec.bottleneck;
  assign out_o.chain_total = rec.chain_total;
  assign out_o.found       = rec.found;
  assign out_o.last        = rec.last;

endmodule

`default_nettype wire
